FILE: src/cartridge_bank_switch_mapper_macros.svh
// Assertion macros shared by the cartridge mapper RTL.
// No dependencies; included inside module bodies after the signals exist.
`ifndef CARTRIDGE_BANK_SWITCH_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_SWITCH_MAPPER_MACROS_SVH

// Plain clocked property, off while reset is asserted
`define CBSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define CBSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/cbsm_pkg.sv
// Shared types and constants for the cartridge bank-switch mapper.
// No dependencies; used by cbsm_bank_ctl and the top level.
package cbsm_pkg;

    // Fixed geometry
    localparam int ROM_BYTES_DEF = 32768;
    localparam int RAM_BYTES     = 256;
    localparam int RAM_AW        = $clog2(RAM_BYTES);
    localparam int BANK_W        = 3;
    localparam int OFF_W         = 12;
    localparam int IDX_W         = 15;
    localparam int SIZE_W        = 17;
    // Largest {bank, offset} or load index plus one
    localparam int ADDR_SPAN     = 2 ** IDX_W;

    // Opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_BOOT  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_IMAGE_SIZE    = 1'b0;
    localparam logic CFG_IMAGE_PRESENT = 1'b1;

    // Image sizes that name a scheme
    localparam logic [SIZE_W-1:0] SIZE_2K  = 17'd2048;
    localparam logic [SIZE_W-1:0] SIZE_4K  = 17'd4096;
    localparam logic [SIZE_W-1:0] SIZE_F8  = 17'd8192;
    localparam logic [SIZE_W-1:0] SIZE_FA  = 17'd12288;
    localparam logic [SIZE_W-1:0] SIZE_F6  = 17'd16384;
    localparam logic [SIZE_W-1:0] SIZE_F4  = 17'd32768;

    // Hotspot offsets
    localparam logic [OFF_W-1:0] HOT_F8_LO = 12'hFF8;
    localparam logic [OFF_W-1:0] HOT_F8_HI = 12'hFF9;
    localparam logic [OFF_W-1:0] HOT_F6_LO = 12'hFF6;
    localparam logic [OFF_W-1:0] HOT_F4_LO = 12'hFF4;
    localparam logic [OFF_W-1:0] HOT_F4_HI = 12'hFFB;
    localparam logic [OFF_W-1:0] HOT_FA_HI = 12'hFFA;

    // FA RAM windows and the 2K mirror
    localparam logic [OFF_W-1:0] RAM_RD_LO   = 12'h100;
    localparam logic [OFF_W-1:0] RAM_RD_HI   = 12'h1FF;
    localparam logic [OFF_W-1:0] MIRROR_MASK = 12'h7FF;
    localparam logic [7:0]       NO_IMAGE_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        SCH_2K,
        SCH_4K,
        SCH_F8,
        SCH_FA,
        SCH_F6,
        SCH_F4
    } t_scheme;

    // Where stage 1 takes the read byte from
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_FF,
        SRC_ROM,
        SRC_RAM
    } t_rd_src;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [OFF_W-1:0] offset;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] image_index;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]        read_data;
        logic [BANK_W-1:0] bank_now;
    } t_out_beat;

    // Top level to bank control
    typedef struct packed {
        logic              accept;
        logic [1:0]        opcode;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] image_size;
        logic              image_present;
    } t_bank_req;

    // Bank control to top level
    typedef struct packed {
        t_scheme           scheme;
        logic [BANK_W-1:0] bank_next;
    } t_bank_info;

endpackage

FILE: src/cbsm_bank_ctl.sv
// Scheme decode, hotspot detection and the bank select register.
// Depends on cbsm_pkg.
module cbsm_bank_ctl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cbsm_pkg::t_bank_req    i_req,
    output cbsm_pkg::t_bank_info   o_info
);
    import cbsm_pkg::*;

    t_scheme           scheme;
    logic [BANK_W-1:0] r_bank;
    logic [BANK_W-1:0] n_bank;
    logic [OFF_W-1:0]  off_f6;
    logic [OFF_W-1:0]  off_f4;
    logic [OFF_W-1:0]  off_fa;
    logic              sw_en;

    // Scheme from the image size
    always_comb begin
        if (i_req.image_size == SIZE_2K) begin
            scheme = SCH_2K;
        end else if (i_req.image_size == SIZE_4K) begin
            scheme = SCH_4K;
        end else if (i_req.image_size == SIZE_F8) begin
            scheme = SCH_F8;
        end else if (i_req.image_size == SIZE_FA) begin
            scheme = SCH_FA;
        end else if (i_req.image_size == SIZE_F6) begin
            scheme = SCH_F6;
        end else if (i_req.image_size == SIZE_F4) begin
            scheme = SCH_F4;
        end else if (i_req.image_size <= SIZE_4K) begin
            scheme = SCH_4K;
        end else begin
            scheme = SCH_F8;
        end
    end

    assign off_f6 = i_req.offset - HOT_F6_LO;
    assign off_f4 = i_req.offset - HOT_F4_LO;
    assign off_fa = i_req.offset - HOT_F8_LO;

    // Reads switch only with an image present; writes always do
    assign sw_en = (i_req.opcode == OP_WRITE) ||
                   ((i_req.opcode == OP_READ) && i_req.image_present);

    // Next bank: hotspot hit or boot
    always_comb begin
        n_bank = r_bank;
        if (i_req.opcode == OP_BOOT) begin
            case (scheme)
                SCH_F8:  n_bank = 3'd1;
                SCH_FA:  n_bank = 3'd2;
                SCH_F6:  n_bank = 3'd3;
                SCH_F4:  n_bank = 3'd7;
                default: n_bank = 3'd0;
            endcase
        end else if (sw_en) begin
            case (scheme)
                SCH_F8: begin
                    if (i_req.offset == HOT_F8_LO) begin
                        n_bank = 3'd0;
                    end else if (i_req.offset == HOT_F8_HI) begin
                        n_bank = 3'd1;
                    end
                end
                SCH_F6: begin
                    if (i_req.offset >= HOT_F6_LO && i_req.offset <= HOT_F8_HI) begin
                        n_bank = off_f6[BANK_W-1:0];
                    end
                end
                SCH_F4: begin
                    if (i_req.offset >= HOT_F4_LO && i_req.offset <= HOT_F4_HI) begin
                        n_bank = off_f4[BANK_W-1:0];
                    end
                end
                SCH_FA: begin
                    if (i_req.offset >= HOT_F8_LO && i_req.offset <= HOT_FA_HI) begin
                        n_bank = off_fa[BANK_W-1:0];
                    end
                end
                default: n_bank = r_bank;
            endcase
        end
    end

    // Bank select register, updated on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= '0;
        end else if (i_req.accept) begin
            r_bank <= n_bank;
        end
    end

    assign o_info.scheme    = scheme;
    assign o_info.bank_next = n_bank;

endmodule

FILE: src/cartridge_bank_switch_mapper.sv
// Cartridge bank-switch mapper top level: config registers, ROM and RAM
// memories, two-stage result pipeline. Depends on cbsm_pkg, cbsm_bank_ctl
// and cartridge_bank_switch_mapper_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_beat) carries one bus
//   access per beat: read, write, image-byte load or boot. Output channel
//   (o_out_valid / i_out_stall / o_out_beat) returns exactly one beat per
//   input beat, in order: the byte read (zero for non-reads) and the bank
//   selected after the access.
//   Throughput: one beat per cycle while o_in_stall is low. Path: an
//   accepted beat is registered in stage 1, where the synchronous ROM and
//   RAM read lands, then in the stage 2 output register.
//   Stage 1 holds the memory read data, stage 2 is the output register, so
//   a new beat is taken while a result waits; o_in_stall rises only when
//   both stages are full and the receiver stalls. The user makes config
//   writes (i_cfg_we, i_cfg_addr, i_cfg_wdata) only while idle; the block
//   does not enforce it. Reset: image size 4096, no image, bank 0, FA RAM
//   reads as zero (per entry valid bits, also cleared by a boot beat). ROM
//   content is undefined until loaded; no clearing pass is run.
module cartridge_bank_switch_mapper #(
    parameter int ROM_BYTES = cbsm_pkg::ROM_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  cbsm_pkg::t_in_beat                 i_in_beat,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output cbsm_pkg::t_out_beat                o_out_beat,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_addr,
    input  logic [cbsm_pkg::SIZE_W-1:0]        i_cfg_wdata
);
    import cbsm_pkg::*;

    localparam int AW       = $clog2(ROM_BYTES);
    localparam int WRAP_MAX = (ADDR_SPAN - 1) / ROM_BYTES;

    // Config registers
    logic [SIZE_W-1:0] r_image_size;
    logic              r_image_present;

    // Pipeline
    logic              acc;
    logic              s1_adv;
    logic              s2_ready;
    logic              r_s1_valid;
    t_rd_src           r_s1_src;
    t_rd_src           n_s1_src;
    logic [BANK_W-1:0] r_s1_bank;
    logic              r_s2_valid;
    t_out_beat         r_s2_beat;
    logic [7:0]        s1_byte;

    // Bank control
    t_bank_req         bank_req;
    t_bank_info        bank_info;

    // Memories
    logic [7:0]        r_rom_mem [ROM_BYTES];
    logic [7:0]        r_rom_q;
    logic [7:0]        r_ram_mem [RAM_BYTES];
    logic [7:0]        r_ram_q;
    logic              r_ram_q_ok;
    logic [RAM_BYTES-1:0] r_ram_vld;
    logic [RAM_AW-1:0] ram_addr;
    logic              ram_we;

    // ROM address forming and wrap
    logic [IDX_W-1:0]  wrap_in;
    logic [31:0]       wrap_full;
    logic [AW-1:0]     rom_addr;

    // Handshake: stage 1 moves when empty or stage 2 can take it
    assign s2_ready   = !r_s2_valid || !i_out_stall;
    assign s1_adv     = !r_s1_valid || s2_ready;
    assign o_in_stall = !s1_adv;
    assign acc        = i_in_valid && s1_adv;

    // Config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size    <= SIZE_4K;
            r_image_present <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IMAGE_SIZE:    r_image_size    <= i_cfg_wdata;
                CFG_IMAGE_PRESENT: r_image_present <= i_cfg_wdata[0];
                default:           r_image_present <= r_image_present;
            endcase
        end
    end

    assign bank_req.accept        = acc;
    assign bank_req.opcode        = i_in_beat.opcode;
    assign bank_req.offset        = i_in_beat.offset;
    assign bank_req.image_size    = r_image_size;
    assign bank_req.image_present = r_image_present;

    cbsm_bank_ctl u_bank_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bank_req),
        .o_info  (bank_info)
    );

    // ROM byte address before wrap; banks are 4K so bank:offset concatenates
    always_comb begin
        if (i_in_beat.opcode == OP_LOAD) begin
            wrap_in = i_in_beat.image_index;
        end else if (bank_info.scheme == SCH_2K) begin
            wrap_in = IDX_W'(i_in_beat.offset & MIRROR_MASK);
        end else if (bank_info.scheme == SCH_4K) begin
            wrap_in = IDX_W'(i_in_beat.offset);
        end else begin
            wrap_in = {bank_info.bank_next, i_in_beat.offset};
        end
    end

    // Modulo ROM size: parallel subtract of each multiple up to 7x, largest fit wins
    always_comb begin
        wrap_full = 32'(wrap_in);
        for (int k = 1; k < 8; k++) begin
            if (k <= WRAP_MAX && 32'(wrap_in) >= 32'(k * ROM_BYTES)) begin
                wrap_full = 32'(wrap_in) - 32'(k * ROM_BYTES);
            end
        end
    end
    assign rom_addr = wrap_full[AW-1:0];

    // ROM: load writes, reads registered; one beat per edge so no overlap
    always_ff @(posedge i_clk) begin
        if (acc && i_in_beat.opcode == OP_LOAD) begin
            r_rom_mem[rom_addr] <= i_in_beat.data_byte;
        end
        if (acc && i_in_beat.opcode == OP_READ) begin
            r_rom_q <= r_rom_mem[rom_addr];
        end
    end

    // FA RAM: written in the low window, read in the next one up
    assign ram_addr = i_in_beat.offset[RAM_AW-1:0];
    assign ram_we   = acc && i_in_beat.opcode == OP_WRITE && bank_info.scheme == SCH_FA &&
                      i_in_beat.offset < RAM_RD_LO;

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_ram_mem[ram_addr] <= i_in_beat.data_byte;
        end
        if (acc && i_in_beat.opcode == OP_READ) begin
            r_ram_q <= r_ram_mem[ram_addr];
        end
    end

    // RAM valid bits: an entry not written since reset or boot reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_vld  <= '0;
            r_ram_q_ok <= 1'b0;
        end else begin
            if (acc && i_in_beat.opcode == OP_BOOT) begin
                r_ram_vld <= '0;
            end else if (ram_we) begin
                r_ram_vld[ram_addr] <= 1'b1;
            end
            if (acc && i_in_beat.opcode == OP_READ) begin
                r_ram_q_ok <= r_ram_vld[ram_addr];
            end
        end
    end

    // Read byte source for the accepted beat
    always_comb begin
        if (i_in_beat.opcode != OP_READ) begin
            n_s1_src = SRC_ZERO;
        end else if (!r_image_present) begin
            n_s1_src = SRC_FF;
        end else if (bank_info.scheme == SCH_FA && i_in_beat.offset >= RAM_RD_LO &&
                     i_in_beat.offset <= RAM_RD_HI) begin
            n_s1_src = SRC_RAM;
        end else begin
            n_s1_src = SRC_ROM;
        end
    end

    // Stage 1: waits on the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_src  <= n_s1_src;
            r_s1_bank <= bank_info.bank_next;
        end
    end

    always_comb begin
        case (r_s1_src)
            SRC_FF:  s1_byte = NO_IMAGE_BYTE;
            SRC_ROM: s1_byte = r_rom_q;
            SRC_RAM: s1_byte = r_ram_q_ok ? r_ram_q : 8'd0;
            default: s1_byte = 8'd0;
        endcase
    end

    // Stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_beat.read_data <= s1_byte;
            r_s2_beat.bank_now  <= r_s1_bank;
        end
    end

    assign o_out_valid = r_s2_valid;
    assign o_out_beat  = r_s2_beat;

    // Checks
`include "cartridge_bank_switch_mapper_macros.svh"

    `CBSM_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n, o_out_valid && !i_out_stall && !r_s1_valid, !o_out_valid, "output stays valid after last beat drained")
    `CBSM_ASSERT_NEXT(a_boot_clears_ram, i_clk, i_rst_n, acc && i_in_beat.opcode == OP_BOOT, r_ram_vld == '0, "boot left FA RAM entries valid")
    `CBSM_ASSERT_NEXT(a_no_image_ff, i_clk, i_rst_n, acc && i_in_beat.opcode == OP_READ && !r_image_present, r_s1_valid && r_s1_src == SRC_FF, "read without image not answered with 0xFF")
    `CBSM_ASSERT_NEXT(a_fa_ram_read, i_clk, i_rst_n, acc && n_s1_src == SRC_RAM, r_s1_src == SRC_RAM && r_s1_bank == $past(bank_info.bank_next), "FA RAM read lost its source or bank")

endmodule
